### design/bsbe_pkg.sv
package bsbe_pkg;

  localparam int unsigned PtrW   = 13;
  localparam int unsigned Lanes  = 8;

  localparam logic [2:0] OP_GET_SEQ = 3'd0;
  localparam logic [2:0] OP_GET_POS = 3'd1;
  localparam logic [2:0] OP_PUT_SEQ = 3'd2;
  localparam logic [2:0] OP_PUT_POS = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] WC_ONE   = 2'd0;
  localparam logic [1:0] WC_TWO   = 2'd1;
  localparam logic [1:0] WC_FOUR  = 2'd2;
  localparam logic [1:0] WC_EIGHT = 2'd3;

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       width_code;
    logic [PtrW-1:0]  position;
    logic [63:0]      write_value;
  } bsbe_cmd_t;

  typedef struct packed {
    logic [63:0]      read_value;
    logic [3:0]       bytes_done;
    logic             overrun;
    logic             overflow;
    logic [PtrW-1:0]  read_pointer;
    logic [PtrW-1:0]  write_end;
  } bsbe_res_t;

  // One access of up to eight consecutive bytes; lane 0 is the byte at the start address.
  typedef struct packed {
    logic                     re;
    logic                     we;
    logic [PtrW-1:0]          from;
    logic [3:0]               count;
    logic [Lanes-1:0][7:0]    wlane;
  } bsbe_mem_req_t;

endpackage

### design/bsbe_ram.sv
module bsbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bsbe_mem.sv
module bsbe_mem #(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  bsbe_pkg::bsbe_mem_req_t       req_i,
  output logic [bsbe_pkg::Lanes-1:0][7:0] rlane_o
);

  import bsbe_pkg::*;

  localparam int unsigned BankDepth = (BUF_DEPTH + 7) / 8;
  localparam int unsigned RowW      = $clog2(BankDepth);

  logic [Lanes-1:0][7:0] bank_rdata;
  logic [2:0]            from_lo_q;

  // Byte i of the buffer lives in bank i mod 8, so any run of eight bytes
  // touches every bank at most once.
  for (genvar b = 0; b < Lanes; b++) begin : g_bank
    logic [2:0]        lane;
    logic [PtrW:0]     idx;
    logic [RowW-1:0]   row;
    logic              ben;

    assign lane = 3'(b) - req_i.from[2:0];
    assign idx  = {1'b0, req_i.from} + (PtrW+1)'(lane);
    assign row  = RowW'(idx[PtrW:3]);
    assign ben  = ({1'b0, lane} < req_i.count);

    bsbe_ram #(
      .WIDTH (8),
      .DEPTH (BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (req_i.we & ben),
      .re_i    (req_i.re & ben),
      .addr_i  (row),
      .wdata_i (req_i.wlane[lane]),
      .rdata_o (bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      from_lo_q <= req_i.from[2:0];
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    logic [2:0] bank_sel;
    assign bank_sel   = from_lo_q + 3'(k);
    assign rlane_o[k] = bank_rdata[bank_sel];
  end

endmodule

### design/byte_stream_buffer_engine_core.sv
// Byte stream buffer. Each command beat (start high while busy is low) reads or writes
// up to eight bytes big-endian, positionally or at the read pointer / write end, or
// clears the pointers and flags. busy is high in the cycle after the beat, in which the
// byte-banked memory is read or written, and the result beat appears on res_o with
// res_valid_o in the cycle after that. That result must be taken as it comes; a new
// command may be given in the same cycle the result shows. This timing is set by the
// registered command and the registered read of the memory banks. Buffer contents are
// undefined after reset until written; pointers, flags and buffer_size reset at once.
module byte_stream_buffer_engine_core #(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bsbe_pkg::bsbe_cmd_t  cmd_i,
  output logic                 res_valid_o,
  output bsbe_pkg::bsbe_res_t  res_o,
  input  logic                 cfg_we_i,
  input  logic [12:0]          cfg_wdata_i
);

  import bsbe_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam logic [16:0] DepthL = 17'(BUF_DEPTH);

  logic            state_q, state_d;
  bsbe_cmd_t       cmd_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] end_ptr_q, end_ptr_d;
  logic            overrun_q, overrun_d;
  logic            overflow_q, overflow_d;
  logic [PtrW-1:0] size_q;
  logic            resp_q;
  logic            resp_get_q, resp_get_d;
  logic [3:0]      done_q, done_d;
  logic [1:0]      wcode_q;

  logic            accept;
  logic [PtrW-1:0] eff_size;
  logic            is_get;
  logic [PtrW-1:0] from;
  logic [PtrW-1:0] limit;
  logic [PtrW-1:0] avail;
  logic [3:0]      nbytes;
  logic            short_acc;
  logic [3:0]      have;
  logic [63:0]     aligned;
  bsbe_mem_req_t   mreq;
  logic [Lanes-1:0][7:0] rlane;
  logic [63:0]     rd_be;
  logic [63:0]     rd_value;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  assign eff_size = ({4'b0, size_q} > DepthL) ? DepthL[PtrW-1:0] : size_q;

  always_comb begin
    is_get = (cmd_q.op == OP_GET_SEQ) || (cmd_q.op == OP_GET_POS);
    case (cmd_q.op)
      OP_GET_SEQ: from = rd_ptr_q;
      OP_PUT_SEQ: from = end_ptr_q;
      default:    from = cmd_q.position;
    endcase
    limit     = is_get ? end_ptr_q : eff_size;
    avail     = (from < limit) ? (limit - from) : '0;
    nbytes    = 4'd1 << cmd_q.width_code;
    short_acc = (avail < {9'b0, nbytes});
    have      = short_acc ? avail[3:0] : nbytes;
  end

  // Put data is moved to the top of the word so that lane 0 carries its first byte.
  always_comb begin
    unique case (cmd_q.width_code)
      WC_ONE:   aligned = {cmd_q.write_value[7:0], 56'b0};
      WC_TWO:   aligned = {cmd_q.write_value[15:0], 48'b0};
      WC_FOUR:  aligned = {cmd_q.write_value[31:0], 32'b0};
      WC_EIGHT: aligned = cmd_q.write_value;
      default:  aligned = cmd_q.write_value;
    endcase
  end

  always_comb begin
    mreq.re    = 1'b0;
    mreq.we    = 1'b0;
    mreq.from  = from;
    mreq.count = have;
    for (int k = 0; k < Lanes; k++) begin
      mreq.wlane[k] = aligned[63-8*k -: 8];
    end

    state_d    = state_q;
    rd_ptr_d   = rd_ptr_q;
    end_ptr_d  = end_ptr_q;
    overrun_d  = overrun_q;
    overflow_d = overflow_q;
    done_d     = 4'd0;
    resp_get_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (cmd_q.op)
          OP_GET_SEQ: begin
            mreq.re    = 1'b1;
            resp_get_d = 1'b1;
            done_d     = have;
            rd_ptr_d   = rd_ptr_q + PtrW'(have);
            overrun_d  = overrun_q | short_acc;
          end
          OP_GET_POS: begin
            mreq.re    = 1'b1;
            resp_get_d = 1'b1;
            done_d     = have;
            overrun_d  = overrun_q | short_acc;
          end
          OP_PUT_SEQ: begin
            mreq.we    = 1'b1;
            done_d     = have;
            end_ptr_d  = end_ptr_q + PtrW'(have);
            overflow_d = overflow_q | short_acc;
          end
          OP_PUT_POS: begin
            mreq.we    = 1'b1;
            done_d     = have;
            overflow_d = overflow_q | short_acc;
          end
          OP_CLEAR: begin
            rd_ptr_d   = '0;
            end_ptr_d  = '0;
            overrun_d  = 1'b0;
            overflow_d = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  bsbe_mem #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rlane_o (rlane)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_ptr_q   <= '0;
      end_ptr_q  <= '0;
      overrun_q  <= 1'b0;
      overflow_q <= 1'b0;
      size_q     <= 13'd4096;
      resp_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_ptr_q   <= rd_ptr_d;
      end_ptr_q  <= end_ptr_d;
      overrun_q  <= overrun_d;
      overflow_q <= overflow_d;
      resp_q     <= (state_q == ST_EXEC);
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_EXEC) begin
      done_q     <= done_d;
      resp_get_q <= resp_get_d;
      wcode_q    <= cmd_q.width_code;
    end
  end

  // Lanes past the bytes actually read come back as zero.
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      rd_be[63-8*k -: 8] = (4'(k) < done_q) ? rlane[k] : 8'h00;
    end
    unique case (wcode_q)
      WC_ONE:   rd_value = {56'b0, rd_be[63:56]};
      WC_TWO:   rd_value = {48'b0, rd_be[63:48]};
      WC_FOUR:  rd_value = {32'b0, rd_be[63:32]};
      WC_EIGHT: rd_value = rd_be;
      default:  rd_value = rd_be;
    endcase
  end

  assign res_valid_o        = resp_q;
  assign res_o.read_value   = resp_get_q ? rd_value : 64'b0;
  assign res_o.bytes_done   = done_q;
  assign res_o.overrun      = overrun_q;
  assign res_o.overflow     = overflow_q;
  assign res_o.read_pointer = rd_ptr_q;
  assign res_o.write_end    = end_ptr_q;

endmodule
